// File: hw/rtl/cia_pkg.sv
// Shared types and constants for the checked integer ALU.
// Holds the command codes, the word payload structs and the pipeline side data.
// Depends on nothing.
package cia_pkg;

  localparam int WORD_BITS = 64;
  localparam int HALF_BITS = WORD_BITS / 2;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  typedef enum logic [3:0] {
    CMD_SHL = 4'd0,
    CMD_SHR = 4'd1,
    CMD_NEG = 4'd2,
    CMD_ADD = 4'd3,
    CMD_SUB = 4'd4,
    CMD_MUL = 4'd5,
    CMD_CMP = 4'd6,
    CMD_DIV = 4'd7,
    CMD_MOD = 4'd8
  } cmd_t;

  typedef struct packed {
    logic        [3:0]  command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               overflow;
    logic               divide_by_zero;
  } out_word_t;

  // Everything an item carries alongside the divider's remainder and quotient.
  typedef struct packed {
    logic [3:0]           cmd;
    logic                 na;
    logic                 nb;
    logic                 dbz;
    logic [WORD_BITS-1:0] ub;
    logic [WORD_BITS-1:0] res;
    logic                 ovf;
  } side_t;

endpackage

// File: hw/rtl/cia_div_stage.sv
// One restoring-division step of the divider pipeline, with its registers.
// Uses cia_pkg for the word width and the side data struct.
module cia_div_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  cia_pkg::side_t                side_in,
  input  logic [cia_pkg::WORD_BITS-1:0] rem_in,
  input  logic [cia_pkg::WORD_BITS-1:0] dq_in,
  output logic                          vld,
  output cia_pkg::side_t                side,
  output logic [cia_pkg::WORD_BITS-1:0] rem,
  output logic [cia_pkg::WORD_BITS-1:0] dq
);

  logic [cia_pkg::WORD_BITS:0]   trial;
  logic [cia_pkg::WORD_BITS:0]   diff;
  logic                          take;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_in, dq_in[cia_pkg::WORD_BITS-1]};
    diff  = trial - {1'b0, side_in.ub};
    take  = !diff[cia_pkg::WORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side <= side_in;
      rem  <= take ? diff[cia_pkg::WORD_BITS-1:0] : trial[cia_pkg::WORD_BITS-1:0];
      dq   <= {dq_in[cia_pkg::WORD_BITS-2:0], take};
    end
  end

endmodule

// File: hw/rtl/checked_integer_alu.sv
// Top level of the checked integer ALU: input capture, operand preparation,
// the divider pipeline built from cia_div_stage, and the floored correction.
// Depends on cia_pkg and cia_div_stage.
//
// Usage: each input word carries a command and two signed operands; each one
// yields exactly one output word with a result and two flags. Both channels
// use valid and ready. A word is taken whenever in_valid and in_ready are high.
//
// Every command takes the same path: one capture stage, one preparation stage
// that forms shifts, checks, compares and the four partial products of the
// multiply, one stage that combines them, one divider stage per quotient bit,
// and the output register. Throughput is one word per cycle while the output
// register is not held; the one-bit-per-stage divider sets the depth.
//
// The whole pipeline advances together. When the output register holds a word
// that the receiver has not taken, every stage holds and in_ready drops; when
// the output slot is empty or being emptied, a new word enters that cycle.
// Reset clears all valid bits, so the block comes up empty and ready.
module checked_integer_alu (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cia_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cia_pkg::out_word_t  out_data
);

  localparam int W = cia_pkg::WORD_BITS;
  localparam int H = cia_pkg::HALF_BITS;
  localparam int C = cia_pkg::CNT_BITS;

  logic en;

  // The pipeline moves when the output slot is free or is being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: capture the word; only the low W bits of each operand count.
  logic         s1_vld;
  logic [3:0]   s1_cmd;
  logic [W-1:0] s1_a;
  logic [W-1:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd <= in_data.command;
      s1_a   <= in_data.operand_a[W-1:0];
      s1_b   <= in_data.operand_b[W-1:0];
    end
  end

  // Stage 2 logic: magnitudes, shifts, simple checks and partial products.
  logic         na, nb;
  logic [W-1:0] ua, ub;
  logic [W-1:0] shl_val, shr_val;
  logic         big_cnt;
  logic [C-1:0] cnt;
  logic [W-1:0] sum, dif;
  logic [W-1:0] s2_res_next;
  logic         s2_ovf_next;

  always_comb begin
    na      = s1_a[W-1];
    nb      = s1_b[W-1];
    ua      = na ? (~s1_a + 1'b1) : s1_a;
    ub      = nb ? (~s1_b + 1'b1) : s1_b;
    // The count magnitude decides both shift directions; MIN gives W or more.
    big_cnt = (ub >= W'(W));
    cnt     = ub[C-1:0];
    shl_val = big_cnt ? '0 : (s1_a << cnt);
    shr_val = big_cnt ? {W{na}} : W'($signed(s1_a) >>> cnt);
    sum     = s1_a + s1_b;
    dif     = s1_a - s1_b;
    s2_res_next = '0;
    s2_ovf_next = 1'b0;
    unique case (cia_pkg::cmd_t'(s1_cmd))
      cia_pkg::CMD_SHL: s2_res_next = nb ? shr_val : shl_val;
      cia_pkg::CMD_SHR: s2_res_next = nb ? shl_val : shr_val;
      cia_pkg::CMD_NEG: s2_ovf_next = (s1_a == {1'b1, {(W-1){1'b0}}});
      cia_pkg::CMD_ADD: s2_ovf_next = (na == nb) && (sum[W-1] != na);
      cia_pkg::CMD_SUB: s2_ovf_next = (na != nb) && (dif[W-1] != na);
      cia_pkg::CMD_CMP: begin
        if (s1_a == s1_b) begin
          s2_res_next = '0;
        end else if ($signed(s1_a) < $signed(s1_b)) begin
          s2_res_next = '1;
        end else begin
          s2_res_next = W'(1);
        end
      end
      default: begin
        s2_res_next = '0;
        s2_ovf_next = 1'b0;
      end
    endcase
  end

  logic         s2_vld;
  logic [3:0]   s2_cmd;
  logic         s2_na, s2_nb, s2_bzero, s2_mzero;
  logic [W-1:0] s2_ua, s2_ub, s2_res;
  logic         s2_ovf;
  logic [W-1:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd   <= s1_cmd;
      s2_na    <= na;
      s2_nb    <= nb;
      s2_ua    <= ua;
      s2_ub    <= ub;
      s2_bzero <= (s1_b == '0);
      s2_mzero <= (s1_a == '0) || (s1_b == '0);
      s2_res   <= s2_res_next;
      s2_ovf   <= s2_ovf_next;
      p00      <= ua[H-1:0] * ub[H-1:0];
      p01      <= ua[H-1:0] * ub[W-1:H];
      p10      <= ua[W-1:H] * ub[H-1:0];
      p11      <= ua[W-1:H] * ub[W-1:H];
    end
  end

  // Stage 3 logic: fold the partial products into a full-width product and
  // compare it against the signed limit.
  logic [H+1:0]   mid;
  logic [W-1:0]   plo;
  logic [W+1:0]   phi;
  logic [W-1:0]   limit;
  logic           mul_ovf;
  cia_pkg::side_t s3_side_next;

  always_comb begin
    mid   = (H+2)'(p00[W-1:H]) + (H+2)'(p01[H-1:0]) + (H+2)'(p10[H-1:0]);
    plo   = {mid[H-1:0], p00[H-1:0]};
    phi   = (W+2)'(p11) + (W+2)'(p01[W-1:H]) + (W+2)'(p10[W-1:H]) + (W+2)'(mid[H+1:H]);
    limit = (s2_na != s2_nb) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    mul_ovf = !s2_mzero && ((phi != '0) || (plo > limit));
    s3_side_next.cmd = s2_cmd;
    s3_side_next.na  = s2_na;
    s3_side_next.nb  = s2_nb;
    s3_side_next.dbz = s2_bzero;
    s3_side_next.ub  = s2_ub;
    s3_side_next.res = s2_res;
    s3_side_next.ovf = (cia_pkg::cmd_t'(s2_cmd) == cia_pkg::CMD_MUL) ? mul_ovf : s2_ovf;
  end

  logic           s3_vld;
  cia_pkg::side_t s3_side;
  logic [W-1:0]   s3_dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= s3_side_next;
      s3_dq   <= s2_ua;
    end
  end

  // Divider: one quotient bit per stage, remainder starting at zero.
  logic           dv_vld  [0:W];
  cia_pkg::side_t dv_side [0:W];
  logic [W-1:0]   dv_rem  [0:W];
  logic [W-1:0]   dv_dq   [0:W];

  assign dv_vld[0]  = s3_vld;
  assign dv_side[0] = s3_side;
  assign dv_rem[0]  = '0;
  assign dv_dq[0]   = s3_dq;

  for (genvar k = 0; k < W; k++) begin : g_div
    cia_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (dv_vld[k]),
      .side_in (dv_side[k]),
      .rem_in  (dv_rem[k]),
      .dq_in   (dv_dq[k]),
      .vld     (dv_vld[k+1]),
      .side    (dv_side[k+1]),
      .rem     (dv_rem[k+1]),
      .dq      (dv_dq[k+1])
    );
  end

  // Output stage: floored correction of quotient and remainder.
  cia_pkg::side_t fs;
  logic [W-1:0]   qm, rm, fres;
  logic           fovf;
  logic           fdbz;

  always_comb begin
    fs   = dv_side[W];
    qm   = dv_dq[W];
    rm   = dv_rem[W];
    fres = fs.res;
    fovf = fs.ovf;
    fdbz = 1'b0;
    unique case (cia_pkg::cmd_t'(fs.cmd))
      cia_pkg::CMD_DIV: begin
        if (fs.dbz) begin
          fres = '0;
          fdbz = 1'b1;
        end else if (fs.na == fs.nb) begin
          fres = qm;
          fovf = (qm == {1'b1, {(W-1){1'b0}}});
        end else begin
          fres = ~qm + ((rm != '0) ? W'(0) : W'(1));
        end
      end
      cia_pkg::CMD_MOD: begin
        if (fs.dbz) begin
          fres = '0;
          fdbz = 1'b1;
        end else if (rm == '0) begin
          fres = '0;
        end else if (fs.na == fs.nb) begin
          fres = fs.nb ? (~rm + 1'b1) : rm;
        end else begin
          fres = fs.nb ? (rm - fs.ub) : (fs.ub - rm);
        end
      end
      default: begin
        fres = fs.res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.result         <= 64'($signed(fres));
      out_data.overflow       <= fovf;
      out_data.divide_by_zero <= fdbz;
    end
  end

endmodule

// File: tb/alu_checker.sv
// Checker for the checked integer ALU: watches both channels, predicts each
// output word from the accepted input word and compares field by field.
// Depends on cia_pkg.
module alu_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  cia_pkg::in_word_t           in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  cia_pkg::out_word_t          out_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cia_pkg::out_word_t awaited_words[$];

  function automatic logic [63:0] shift_up(logic [63:0] v, logic [63:0] cnt);
    if (cnt >= 64) return '0;
    return v << cnt;
  endfunction

  function automatic logic [63:0] shift_down(logic [63:0] v, logic [63:0] cnt);
    if (cnt >= 64) return {64{v[63]}};
    return $signed(v) >>> cnt;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic cia_pkg::out_word_t alu_result(cia_pkg::in_word_t w);
    cia_pkg::out_word_t o;
    logic [63:0] a, b, ua, ub, qm, rm, s, lim;
    logic [127:0] prod;
    a = w.operand_a;
    b = w.operand_b;
    o = '0;
    case (w.command)
      cia_pkg::CMD_SHL: o.result = b[63] ? shift_down(a, mag(b)) : shift_up(a, b);
      cia_pkg::CMD_SHR: o.result = b[63] ? shift_up(a, mag(b)) : shift_down(a, b);
      cia_pkg::CMD_NEG: o.overflow = (a == {1'b1, 63'd0});
      cia_pkg::CMD_ADD: begin
        s = a + b;
        o.overflow = (a[63] == b[63]) && (s[63] != a[63]);
      end
      cia_pkg::CMD_SUB: begin
        s = a - b;
        o.overflow = (a[63] != b[63]) && (s[63] != a[63]);
      end
      cia_pkg::CMD_MUL: begin
        prod = {64'd0, mag(a)} * {64'd0, mag(b)};
        lim = (a[63] != b[63]) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        o.overflow = (prod[127:64] != 0) || (prod[63:0] > lim);
      end
      cia_pkg::CMD_CMP: begin
        if (a == b) o.result = '0;
        else if ($signed(a) < $signed(b)) o.result = '1;
        else o.result = 64'd1;
      end
      cia_pkg::CMD_DIV, cia_pkg::CMD_MOD: begin
        if (b == 0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          ua = mag(a);
          ub = mag(b);
          qm = ua / ub;
          rm = ua % ub;
          if (w.command == cia_pkg::CMD_DIV) begin
            if (a[63] == b[63]) begin
              o.result = qm;
              o.overflow = (qm == {1'b1, 63'd0});
            end else begin
              o.result = -qm - 64'(rm != 0);
            end
          end else if (rm == 0) begin
            o.result = '0;
          end else if (a[63] == b[63]) begin
            o.result = b[63] ? -rm : rm;
          end else begin
            o.result = b[63] ? -(ub - rm) : ub - rm;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    cia_pkg::out_word_t exp_w;
    int n_err;
    n_err = 0;
    if (rst) begin
      errors  <= 0;
      pending <= awaited_words.size();
    end else begin
      if (in_valid && in_ready) awaited_words.push_back(alu_result(in_data));
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: unexpected word result=%h", $time, out_data.result);
          n_err++;
        end else begin
          exp_w = awaited_words.pop_front();
          if (exp_w.result !== out_data.result) begin
            $display("%0t: result expected %h actual %h", $time, exp_w.result,
                     out_data.result);
            n_err++;
          end
          if (exp_w.overflow !== out_data.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, exp_w.overflow,
                     out_data.overflow);
            n_err++;
          end
          if (exp_w.divide_by_zero !== out_data.divide_by_zero) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     exp_w.divide_by_zero, out_data.divide_by_zero);
            n_err++;
          end
        end
      end
      errors  <= errors + n_err;
      pending <= awaited_words.size();
    end
  end
endmodule

// File: tb/testbench.sv
// Top of the checked integer ALU testbench: clock, reset, stimulus and verdict.
// Depends on cia_pkg, checked_integer_alu and alu_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MIN_V = {1'b1, 63'd0};
  localparam logic [63:0] MAX_V = {1'b0, {63{1'b1}}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cia_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cia_pkg::out_word_t out_data;
  int                 errors;
  int                 pending;

  // Idle percentages for each side, changed between phases by the stimulus.
  int send_idle = 36;
  int recv_idle = 70;
  // When set, the receiver holds off for a long stretch of its own counting.
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  checked_integer_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  alu_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  // Receiver: random ready, except for the long hold that fills the pipeline
  // so that in_ready is seen to drop while the sender keeps offering words.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
        @(posedge clk);
      end
    end
  end

  // Offers one word and returns once it has been taken. Valid stays high
  // straight into the next word unless the sender decides to idle first.
  task automatic send_word(input cia_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_cmd(input logic [3:0] c, input logic [63:0] a,
                          input logic [63:0] b);
    cia_pkg::in_word_t w;
    w.command = c;
    w.operand_a = a;
    w.operand_b = b;
    send_word(w);
  endtask

  // Operands lean on the edges: zero, one, minus one, the extremes, small
  // values and random words of random size, with fully random words for the rest.
  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 64'd1;
      2: v = '1;
      3: v = MIN_V;
      4: v = MAX_V;
      5: v = 64'($signed($urandom_range(200)) - 100);
      6: v = {$urandom, $urandom} >> $urandom_range(63);
      7: v = -({$urandom, $urandom} >> $urandom_range(63));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_random(input int n);
    logic [3:0]  c;
    logic [63:0] b;
    for (int i = 0; i < n; i++) begin
      // Mostly real commands; the unused codes show up now and then.
      c = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                    : 4'($urandom_range(8));
      b = pick_operand();
      if ((c == cia_pkg::CMD_SHL || c == cia_pkg::CMD_SHR) && $urandom_range(2) != 0)
        b = 64'($signed($urandom_range(150)) - 75);
      send_cmd(c, pick_operand(), b);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: every command with the corner cases it has.
    send_cmd(cia_pkg::CMD_SHL, 64'h1, 64'd63);
    send_cmd(cia_pkg::CMD_SHL, 64'h3, 64'd64);
    send_cmd(cia_pkg::CMD_SHL, MIN_V, -64'sd1);
    send_cmd(cia_pkg::CMD_SHL, 64'hF0, MIN_V);
    send_cmd(cia_pkg::CMD_SHR, MIN_V, 64'd63);
    send_cmd(cia_pkg::CMD_SHR, MIN_V, 64'd100);
    send_cmd(cia_pkg::CMD_SHR, 64'h5, -64'sd2);
    send_cmd(cia_pkg::CMD_NEG, MIN_V, '0);
    send_cmd(cia_pkg::CMD_NEG, MAX_V, '0);
    send_cmd(cia_pkg::CMD_ADD, MAX_V, 64'd1);
    send_cmd(cia_pkg::CMD_ADD, MIN_V, '1);
    send_cmd(cia_pkg::CMD_SUB, MIN_V, 64'd1);
    send_cmd(cia_pkg::CMD_SUB, '0, MIN_V);
    send_cmd(cia_pkg::CMD_MUL, MIN_V, 64'd1);
    send_cmd(cia_pkg::CMD_MUL, MIN_V, '1);
    send_cmd(cia_pkg::CMD_MUL, 64'h1_0000_0000, 64'h8000_0000);
    send_cmd(cia_pkg::CMD_CMP, MIN_V, MAX_V);
    send_cmd(cia_pkg::CMD_CMP, '1, '1);
    send_cmd(cia_pkg::CMD_DIV, MIN_V, '1);
    send_cmd(cia_pkg::CMD_DIV, -64'sd7, 64'd2);
    send_cmd(cia_pkg::CMD_DIV, 64'd7, '0);
    send_cmd(cia_pkg::CMD_MOD, MIN_V, '1);
    send_cmd(cia_pkg::CMD_MOD, 64'd7, -64'sd2);
    send_cmd(cia_pkg::CMD_MOD, MAX_V, '0);
    send_cmd(4'd15, MAX_V, MIN_V);

    // The sender pauses here until every result is back.
    wait_drained();

    send_random(200);
    send_idle = 70;
    recv_idle = 36;
    send_random(200);
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    send_random(200);

    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
